[rtl/krt_pkg.sv]
// Shared request, status and state codes for the keyed record table.
package krt_pkg;

    localparam int KEY_W       = 32;
    localparam int PORT_PAY_W  = 64;
    localparam int PORT_CNT_W  = 9;

    typedef enum logic [1:0] {
        REQ_UPSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_CLEAN  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // control part of the search token walking down the cell chain
    typedef struct packed {
        logic valid;
        logic del;   // delete: capture the last live entry
        logic hit;   // key matched in an earlier cell
    } tok_ctl_t;

endpackage

[rtl/krt_cell.sv]
// One table entry plus one stage of the search token pipeline.
module krt_cell
    import krt_pkg::*;
#(
    parameter int CAPACITY      = 256,
    parameter int PAYLOAD_WIDTH = 64,
    parameter int IDX           = 0
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(CAPACITY+1)-1:0]     count,
    input  logic [KEY_W-1:0]                  srch_key,
    input  tok_ctl_t                          tok_ctl_in,
    input  logic [$clog2(CAPACITY)-1:0]       tok_idx_in,
    input  logic [KEY_W-1:0]                  cap_key_in,
    input  logic [PAYLOAD_WIDTH-1:0]          cap_pay_in,
    output tok_ctl_t                          tok_ctl_out,
    output logic [$clog2(CAPACITY)-1:0]       tok_idx_out,
    output logic [KEY_W-1:0]                  cap_key_out,
    output logic [PAYLOAD_WIDTH-1:0]          cap_pay_out,
    input  logic                              wr_en,
    input  logic [$clog2(CAPACITY)-1:0]       wr_idx,
    input  logic [KEY_W-1:0]                  wr_key,
    input  logic [PAYLOAD_WIDTH-1:0]          wr_pay
);

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);
    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);

    logic [KEY_W-1:0]         key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    tok_ctl_t                 tok_ctl_reg, tok_ctl_next;
    logic [IDX_W-1:0]         tok_idx_reg, tok_idx_next;
    logic [KEY_W-1:0]         cap_key_reg, cap_key_next;
    logic [PAYLOAD_WIDTH-1:0] cap_pay_reg, cap_pay_next;

    logic live, is_last, match, grab;

    assign live    = (MY_POS < count);
    assign is_last = (MY_NEXT == count);
    assign match   = tok_ctl_in.valid && live && !tok_ctl_in.hit && (key_reg == srch_key);
    assign grab    = tok_ctl_in.del ? (tok_ctl_in.valid && is_last) : match;

    always_comb
    begin
        tok_ctl_next       = tok_ctl_in;
        tok_ctl_next.hit   = tok_ctl_in.hit | match;
        tok_idx_next       = match ? MY_IDX : tok_idx_in;
        cap_key_next       = grab ? key_reg : cap_key_in;
        cap_pay_next       = grab ? pay_reg : cap_pay_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_ctl_reg <= '0;
        end
        else
        begin
            tok_ctl_reg <= tok_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_idx_reg <= tok_idx_next;
        cap_key_reg <= cap_key_next;
        cap_pay_reg <= cap_pay_next;
        if (wr_en && (wr_idx == MY_IDX))
        begin
            key_reg <= wr_key;
            pay_reg <= wr_pay;
        end
    end

    assign tok_ctl_out = tok_ctl_reg;
    assign tok_idx_out = tok_idx_reg;
    assign cap_key_out = cap_key_reg;
    assign cap_pay_out = cap_pay_reg;

endmodule

[rtl/krt_ctrl.sv]
// Request sequencer: launches the search token, applies the update, holds the result.
module krt_ctrl
    import krt_pkg::*;
#(
    parameter int CAPACITY      = 256,
    parameter int PAYLOAD_WIDTH = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [KEY_W-1:0]                  entry_key,
    input  logic [PORT_PAY_W-1:0]             entry_payload,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [PORT_PAY_W-1:0]             found_payload,
    output logic [PORT_CNT_W-1:0]             entry_count,
    output logic                              dirty,
    output logic [$clog2(CAPACITY+1)-1:0]     count,
    output logic [KEY_W-1:0]                  srch_key,
    output tok_ctl_t                          tok_inject,
    input  tok_ctl_t                          tok_end_ctl,
    input  logic [$clog2(CAPACITY)-1:0]       tok_end_idx,
    input  logic [KEY_W-1:0]                  tok_end_key,
    input  logic [PAYLOAD_WIDTH-1:0]          tok_end_pay,
    output logic                              wr_en,
    output logic [$clog2(CAPACITY)-1:0]       wr_idx,
    output logic [KEY_W-1:0]                  wr_key,
    output logic [PAYLOAD_WIDTH-1:0]          wr_pay
);

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t                   state_reg, state_next;
    req_t                     req_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     dirty_reg, dirty_next;
    logic                     inj_reg, inj_next;
    logic                     del_reg;

    // captured token at the end of the chain
    logic                     res_hit_reg;
    logic [IDX_W-1:0]         res_idx_reg;
    logic [KEY_W-1:0]         res_key_reg;
    logic [PAYLOAD_WIDTH-1:0] res_pay_reg;

    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic [PORT_PAY_W-1:0]    found_reg, found_next;
    logic [PORT_CNT_W-1:0]    ecount_reg, ecount_next;
    logic                     odirty_reg, odirty_next;

    logic accept, needs_scan, out_free, commit;

    assign accept     = in_valid && !in_stall;
    assign needs_scan = (req_t'(req_type) != REQ_CLEAN) && (entry_key != '0);
    assign out_free   = !(out_valid_reg && out_stall);
    assign commit     = (state_reg == S_FINISH) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (tok_end_ctl.valid)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // update and result
    always_comb
    begin
        count_next     = count_reg;
        dirty_next     = dirty_reg;
        inj_next       = accept && needs_scan;
        status_next    = status_reg;
        found_next     = found_reg;
        ecount_next    = ecount_reg;
        odirty_next    = odirty_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en          = 1'b0;
        wr_idx         = res_idx_reg;
        wr_key         = key_reg;
        wr_pay         = pay_reg;

        if (commit)
        begin
            status_next = ST_OK;
            found_next  = '0;
            if (req_reg == REQ_CLEAN)
            begin
                dirty_next = 1'b0;
            end
            else if (key_reg == '0)
            begin
                status_next = ST_INVALID;
            end
            else
            begin
                unique case (req_reg)
                    REQ_UPSERT:
                    begin
                        if (res_hit_reg)
                        begin
                            wr_en      = 1'b1;
                            dirty_next = 1'b1;
                        end
                        else if (count_reg >= CAP_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_idx     = IDX_W'(count_reg);
                            count_next = count_reg + 1'b1;
                            dirty_next = 1'b1;
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (res_hit_reg)
                        begin
                            found_next = PORT_PAY_W'(res_pay_reg);
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (res_hit_reg)
                        begin
                            wr_en      = 1'b1;
                            wr_key     = res_key_reg;
                            wr_pay     = res_pay_reg;
                            count_next = count_reg - 1'b1;
                            dirty_next = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            ecount_next    = PORT_CNT_W'(count_next);
            odirty_next    = dirty_next;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dirty_reg     <= 1'b0;
            inj_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dirty_reg     <= dirty_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
        ecount_reg <= ecount_next;
        odirty_reg <= odirty_next;
        if (accept)
        begin
            req_reg <= req_t'(req_type);
            key_reg <= entry_key;
            pay_reg <= entry_payload[PAYLOAD_WIDTH-1:0];
            del_reg <= (req_t'(req_type) == REQ_DELETE);
        end
        if (accept && !needs_scan)
        begin
            res_hit_reg <= 1'b0;
        end
        else if ((state_reg == S_SCAN) && tok_end_ctl.valid)
        begin
            res_hit_reg <= tok_end_ctl.hit;
            res_idx_reg <= tok_end_idx;
            res_key_reg <= tok_end_key;
            res_pay_reg <= tok_end_pay;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found_payload = found_reg;
    assign entry_count   = ecount_reg;
    assign dirty         = odirty_reg;
    assign count         = count_reg;
    assign srch_key      = key_reg;

    always_comb
    begin
        tok_inject       = '0;
        tok_inject.valid = inj_reg;
        tok_inject.del   = del_reg;
    end

endmodule

[rtl/keyed_record_table.sv]
// Top level of the keyed record table: sequencer plus a chain of entry cells.
//
// Usage
//   Request channel: in_valid / in_stall with req_type, entry_key and
//   entry_payload. Result channel: out_valid / out_stall with status,
//   found_payload, entry_count and dirty. A transfer happens on a rising
//   edge with valid high and stall low; one result per request, in order.
// Timing
//   A search token enters cell 0 and moves one cell per cycle down the
//   CAPACITY cells. A request with a nonzero key goes to S_FINISH when the
//   token leaves the last cell; the result is then registered to out_valid.
//   Mark clean and key zero bypass the chain: acceptance leads straight to
//   S_FINISH and the result is registered from there.
//   One request is in work at a time; in_stall is high while it is.
// Reset
//   rst_n clears the entry count, dirty mark, token and result valid.
//   Entry contents are not cleared; only entries below the count are read.
// Stall
//   A new request is accepted while a result waits; its own result holds in
//   the final step (no update applied) until out_stall drops.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int CAPACITY      = 256,
    parameter int PAYLOAD_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             req_type,
    input  logic [KEY_W-1:0]       entry_key,
    input  logic [PORT_PAY_W-1:0]  entry_payload,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic [PORT_PAY_W-1:0]  found_payload,
    output logic [PORT_CNT_W-1:0]  entry_count,
    output logic                   dirty
);

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [CNT_W-1:0]         count;
    logic [KEY_W-1:0]         srch_key;

    // token links; link k feeds cell k, link CAPACITY is the chain end
    tok_ctl_t                 tok_ctl [CAPACITY+1];
    logic [IDX_W-1:0]         tok_idx [CAPACITY+1];
    logic [KEY_W-1:0]         cap_key [CAPACITY+1];
    logic [PAYLOAD_WIDTH-1:0] cap_pay [CAPACITY+1];

    // single write port broadcast to every cell
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic [KEY_W-1:0]         wr_key;
    logic [PAYLOAD_WIDTH-1:0] wr_pay;

    krt_ctrl #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .entry_key     (entry_key),
        .entry_payload (entry_payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_payload (found_payload),
        .entry_count   (entry_count),
        .dirty         (dirty),
        .count         (count),
        .srch_key      (srch_key),
        .tok_inject    (tok_ctl[0]),
        .tok_end_ctl   (tok_ctl[CAPACITY]),
        .tok_end_idx   (tok_idx[CAPACITY]),
        .tok_end_key   (cap_key[CAPACITY]),
        .tok_end_pay   (cap_pay[CAPACITY]),
        .wr_en         (wr_en),
        .wr_idx        (wr_idx),
        .wr_key        (wr_key),
        .wr_pay        (wr_pay)
    );

    // token starts with no hit and nothing captured
    assign tok_idx[0] = '0;
    assign cap_key[0] = '0;
    assign cap_pay[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        krt_cell #(
            .CAPACITY      (CAPACITY),
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
            .IDX           (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .count       (count),
            .srch_key    (srch_key),
            .tok_ctl_in  (tok_ctl[i]),
            .tok_idx_in  (tok_idx[i]),
            .cap_key_in  (cap_key[i]),
            .cap_pay_in  (cap_pay[i]),
            .tok_ctl_out (tok_ctl[i+1]),
            .tok_idx_out (tok_idx[i+1]),
            .cap_key_out (cap_key[i+1]),
            .cap_pay_out (cap_pay[i+1]),
            .wr_en       (wr_en),
            .wr_idx      (wr_idx),
            .wr_key      (wr_key),
            .wr_pay      (wr_pay)
        );
    end

endmodule
